### hdl/assert_macros.svh
// Assertion macros used by the ordered list engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An antecedent that implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ole_pkg.sv
// Package with the types, codes and constants of the ordered list engine.
`timescale 1ns / 1ps

package ole_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 4;
    localparam int LEN_W    = 5;

    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FIDX_W + VALUE_W + LEN_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_DEL_VALUE = 3'd3,
        OP_DEL_POS   = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PULL_RD,
        S_PULL_WR,
        S_PUSH_RD,
        S_PUSH_WR,
        S_READ_RD,
        S_READ_OUT,
        S_RESULT
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_POS,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_sel_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_NEXT,
        RA_PREV
    } rd_addr_sel_t;

    typedef enum logic {
        WA_IDX,
        WA_COUNT
    } wr_addr_sel_t;

    typedef enum logic {
        WD_VALUE,
        WD_READ
    } wr_data_sel_t;

    typedef struct packed {
        logic         load_req;
        idx_sel_t     idx_sel;
        logic         rd_en;
        rd_addr_sel_t rd_addr_sel;
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        logic         count_inc;
        logic         count_dec;
        logic         fidx_load;
        logic         rval_load;
        logic         stat_load;
        status_t      stat_code;
        logic         res_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic count_full;
        logic pos_gt_count;
        logic pos_ge_count;
        logic idx_last;
        logic idx_at_pos;
        logic match;
        logic out_free;
    } sts_t;

endpackage

### hdl/ole_datapath.sv
// Datapath of the ordered list engine: list memory, request, index, count and result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ole_datapath
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  op_t                        in_op,
    input  logic signed [VALUE_W-1:0]  in_value,
    input  logic        [POS_W-1:0]    in_position,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output status_t                    out_status,
    output logic        [FIDX_W-1:0]   out_found_index,
    output logic signed [VALUE_W-1:0]  out_read_value,
    output logic        [LEN_W-1:0]    out_length
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    op_t                       op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic        [POS_W-1:0]   pos_reg;
    logic        [AW-1:0]      idx_reg;
    logic        [AW-1:0]      idx_next;
    logic        [CW-1:0]      count_reg;
    logic        [CW-1:0]      count_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic        [AW-1:0]      fidx_reg;
    logic signed [VALUE_W-1:0] rval_reg;
    status_t                   stat_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   out_status_reg;
    logic        [FIDX_W-1:0]  out_fidx_reg;
    logic signed [VALUE_W-1:0] out_rval_reg;
    logic        [LEN_W-1:0]   out_len_reg;

    logic        [AW-1:0]      rd_addr;
    logic        [AW-1:0]      wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic        [CMPW-1:0]    pos_ext;
    logic        [CMPW-1:0]    cnt_ext;

    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(count_reg);

    always_comb
    begin
        case (cmd.idx_sel)
            IDX_ZERO:  idx_next = '0;
            IDX_POS:   idx_next = AW'(pos_ext);
            IDX_COUNT: idx_next = AW'(count_reg);
            IDX_INC:   idx_next = idx_reg + AW'(1);
            IDX_DEC:   idx_next = idx_reg - AW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_addr_sel)
            RA_NEXT: rd_addr = idx_reg + AW'(1);
            RA_PREV: rd_addr = idx_reg - AW'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    assign wr_addr = (cmd.wr_addr_sel == WA_COUNT) ? AW'(count_reg) : idx_reg;
    assign wr_data = (cmd.wr_data_sel == WD_READ) ? rd_data_reg : value_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // List storage with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
        idx_reg <= idx_next;
        if (cmd.load_req)
        begin
            fidx_reg <= '0;
            rval_reg <= '0;
            stat_reg <= ST_OK;
        end
        else
        begin
            if (cmd.fidx_load)
            begin
                fidx_reg <= idx_reg;
            end
            if (cmd.rval_load)
            begin
                rval_reg <= rd_data_reg;
            end
            if (cmd.stat_load)
            begin
                stat_reg <= cmd.stat_code;
            end
        end
        if (cmd.res_load)
        begin
            out_status_reg <= stat_reg;
            out_fidx_reg   <= FIDX_W'(fidx_reg);
            out_rval_reg   <= rval_reg;
            out_len_reg    <= LEN_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.op           = op_reg;
    assign sts.count_zero   = (count_reg == '0);
    assign sts.count_full   = (count_reg >= CW'(CAPACITY));
    assign sts.pos_gt_count = (pos_ext > cnt_ext);
    assign sts.pos_ge_count = (pos_ext >= cnt_ext);
    assign sts.idx_last     = ((CW'(idx_reg) + CW'(1)) >= count_reg);
    assign sts.idx_at_pos   = (CMPW'(idx_reg) == pos_ext);
    assign sts.match        = (rd_data_reg == value_reg);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_found_index = out_fidx_reg;
    assign out_read_value  = out_rval_reg;
    assign out_length      = out_len_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "entry count exceeds capacity")
    `ASSERT_IMPLIES(a_append_room, cmd.wr_en && (cmd.wr_addr_sel == WA_COUNT),
        count_reg < CW'(CAPACITY), "tail write into a full list")
    `ASSERT_IMPLIES(a_result_slot, cmd.res_load, sts.out_free, "result overwrites a pending beat")
    `ASSERT_NEXT(a_result_len, cmd.res_load,
        out_valid_reg && (out_len_reg == LEN_W'($past(count_reg))), "result length mismatch")

endmodule

### hdl/ole_ctrl.sv
// Controller state machine of the ordered list engine.
`timescale 1ns / 1ps

module ole_ctrl
    import ole_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (sts.count_zero || sts.pos_gt_count || sts.count_full)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_PUSH_RD;
                        end
                    end
                    OP_SEARCH, OP_DEL_VALUE:
                    begin
                        state_next = sts.count_zero ? S_RESULT : S_SRCH_RD;
                    end
                    OP_DEL_POS:
                    begin
                        state_next = (sts.count_zero || sts.pos_ge_count) ? S_RESULT : S_PULL_RD;
                    end
                    OP_READ:
                    begin
                        state_next = (sts.count_zero || sts.pos_ge_count) ? S_RESULT : S_READ_RD;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (sts.match)
                begin
                    state_next = (sts.op == OP_DEL_VALUE) ? S_PULL_RD : S_RESULT;
                end
                else if (sts.idx_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_PULL_RD:
            begin
                state_next = sts.idx_last ? S_RESULT : S_PULL_WR;
            end
            S_PULL_WR:
            begin
                state_next = S_PULL_RD;
            end
            S_PUSH_RD:
            begin
                state_next = sts.idx_at_pos ? S_RESULT : S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                state_next = S_PUSH_RD;
            end
            S_READ_RD:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.idx_sel     = IDX_HOLD;
        cmd.rd_addr_sel = RA_IDX;
        cmd.wr_addr_sel = WA_IDX;
        cmd.wr_data_sel = WD_VALUE;
        cmd.stat_code   = ST_OK;
        in_ready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_DECIDE:
            begin
                case (sts.op)
                    OP_APPEND:
                    begin
                        if (sts.count_full)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = WA_COUNT;
                            cmd.count_inc   = 1'b1;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_EMPTY;
                        end
                        else if (sts.pos_gt_count)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_RANGE;
                        end
                        else if (sts.count_full)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_COUNT;
                        end
                    end
                    OP_SEARCH, OP_DEL_VALUE:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_ZERO;
                        end
                    end
                    OP_DEL_POS, OP_READ:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_EMPTY;
                        end
                        else if (sts.pos_ge_count)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_POS;
                        end
                    end
                    default:
                    begin
                        cmd.stat_load = 1'b0;
                    end
                endcase
            end
            S_SRCH_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_SRCH_CMP:
            begin
                if (sts.match)
                begin
                    cmd.fidx_load = 1'b1;
                end
                else if (sts.idx_last)
                begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = ST_NOTFOUND;
                end
                else
                begin
                    cmd.idx_sel = IDX_INC;
                end
            end
            S_PULL_RD:
            begin
                if (sts.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = RA_NEXT;
                end
            end
            S_PULL_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_data_sel = WD_READ;
                cmd.idx_sel     = IDX_INC;
            end
            S_PUSH_RD:
            begin
                if (sts.idx_at_pos)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.count_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr_sel = RA_PREV;
                end
            end
            S_PUSH_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_data_sel = WD_READ;
                cmd.idx_sel     = IDX_DEC;
            end
            S_READ_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_READ_OUT:
            begin
                cmd.rval_load = 1'b1;
            end
            S_RESULT:
            begin
                cmd.res_load = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/ordered_list_engine.sv
// Top level of the ordered list engine: stream ports, controller and datapath.
// Each request is taken while idle and then decided on: an append writes at the tail, a search
// or delete by value reads and compares entry by entry, an insert or delete shifts entries with
// a read and a write each, a read fetches its entry, and the result then goes to the output register.
// Only one request is in flight; the next is taken once its result has been handed over.
// Reset (rst_n, asynchronous, active low) empties the list and clears the pending result at once.
`timescale 1ns / 1ps

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value[31:0], position[36:32], zero padding
    input  logic [OP_W-1:0]       s_tuser,   // op[2:0]
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // found_index[3:0], read_value[35:4],
                                             // length[40:36], zero padding
    output logic [STATUS_W-1:0]   m_tuser    // status[2:0]
);

    // The controller sequences each request through the datapath. It only ever holds one
    // request, so the request channel is ready solely while the controller is idle. The result
    // sits in an output register inside the datapath, so the controller returns to idle as soon
    // as it has handed the result over, and the next request may arrive while that beat waits.

    cmd_t                      cmd;
    sts_t                      sts;
    status_t                   out_status;
    logic        [FIDX_W-1:0]  out_found_index;
    logic signed [VALUE_W-1:0] out_read_value;
    logic        [LEN_W-1:0]   out_length;
    logic signed [VALUE_W-1:0] in_value;
    logic        [POS_W-1:0]   in_position;
    op_t                       in_op;

    // Unpack the request beat. Operation codes outside the defined set pass through and are
    // answered with an ok status and no change to the list.
    assign in_value    = s_tdata[VALUE_W-1:0];
    assign in_position = s_tdata[VALUE_W +: POS_W];
    assign in_op       = op_t'(s_tuser);

    ole_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the list memory (no reset: entries at or beyond the count are never
    // read), the entry count, the request registers and the result register.
    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_op           (in_op),
        .in_value        (in_value),
        .in_position     (in_position),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_found_index (out_found_index),
        .out_read_value  (out_read_value),
        .out_length      (out_length)
    );

    // Pack the result beat, lowest field first, padded with zeros to whole bytes.
    assign m_tdata = M_TDATA_W'({out_length, out_read_value, out_found_index});
    assign m_tuser = out_status;

endmodule
